FILE: design/hbs_pkg.sv
// Package for the heightmap bilinear sampler: word types, register indexes, constants.
// No dependencies.
package hbs_pkg;
    localparam logic [2:0] REG_MAP_PRESENT  = 3'd0;
    localparam logic [2:0] REG_WORLD_WIDTH  = 3'd1;
    localparam logic [2:0] REG_WORLD_DEPTH  = 3'd2;
    localparam logic [2:0] REG_GRID_COLUMNS = 3'd3;
    localparam logic [2:0] REG_GRID_ROWS    = 3'd4;
    localparam logic       KIND_WRITE = 1'b0;
    localparam logic       KIND_QUERY = 1'b1;
    localparam int         QDIV_STEPS = 17;

    typedef struct packed {
        logic               kind;
        logic [15:0]        cell_index;
        logic signed [31:0] cell_height;
        logic signed [31:0] query_x;
        logic signed [31:0] query_z;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] height;
        logic               inside_res;
    } t_out_word;
endpackage

FILE: design/hbs_if.sv
// Valid/ready channel interface carrying one word of type T.
// The word type is a parameter; no dependencies.
interface hbs_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: design/hbs_div.sv
// Pipelined restoring divider: floor(mag * 65536 / den), one quotient bit per stage
// over QDIV_STEPS stages, with a flag when the quotient does not fit. Depends on hbs_pkg.
module hbs_div
    import hbs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_mag,
    input  logic        i_neg,
    input  logic [30:0] i_den,
    output logic [16:0] o_quo,
    output logic        o_neg,
    output logic        o_big,
    output logic        o_inexact
);
    genvar g;
    generate
        for (g = 0; g < QDIV_STEPS; g++) begin : g_st
            logic [31:0] r_rem;
            logic [16:0] r_quo;
            logic        r_neg;
            logic        r_big;
            logic [31:0] n_part;
            logic [16:0] n_prev;
            logic        n_pneg;
            logic        n_pbig;
            logic [32:0] n_try;
            if (g == 0) begin : g_first
                // quotient fits 17 bits unless mag >= 2 * den
                assign n_part = i_mag;
                assign n_prev = '0;
                assign n_pneg = i_neg;
                assign n_pbig = (i_mag >= {i_den, 1'b0});
            end else begin : g_next
                assign n_part = {g_st[g-1].r_rem[30:0], 1'b0};
                assign n_prev = g_st[g-1].r_quo;
                assign n_pneg = g_st[g-1].r_neg;
                assign n_pbig = g_st[g-1].r_big;
            end
            assign n_try = {1'b0, n_part} - {2'b0, i_den};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem <= n_try[32] ? n_part : n_try[31:0];
                    r_quo <= {n_prev[15:0], ~n_try[32]};
                    r_neg <= n_pneg;
                    r_big <= n_pbig;
                end
            end
        end
    endgenerate

    assign o_quo     = g_st[QDIV_STEPS-1].r_quo;
    assign o_neg     = g_st[QDIV_STEPS-1].r_neg;
    assign o_big     = g_st[QDIV_STEPS-1].r_big;
    assign o_inexact = (g_st[QDIV_STEPS-1].r_rem != '0);
endmodule

FILE: design/heightmap_bilinear_sampler.sv
// Heightmap bilinear sampler top level: divider, cell, memory and lerp stages.
// Depends on hbs_pkg, hbs_if and hbs_div.
//
//  channel | dir | word       | handshake
//  s_in    | in  | t_in_word  | valid/ready
//  m_out   | out | t_out_word | valid/ready
//  cfg     | in  | reg index  | write enable
//
// One word per cycle while m_out is not stalled; an answer is valid once its word has passed
// the 17 divider stages, then the mapping, scaling, address, memory, x and z lerp stages.
// Grid writes travel the same pipeline and land at the memory stage, in order with queries.
// Reset clears valid bits and sets the config registers to defaults; the height memory is not cleared.
// A stall on m_out freezes the whole pipeline; nothing is dropped.
module heightmap_bilinear_sampler
    import hbs_pkg::*;
#(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hbs_if.sink         s_in,
    hbs_if.source       m_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [30:0] i_cfg_data
);
    typedef struct packed {
        logic        query;
        logic [15:0] idx;
        logic [31:0] hgt;
    } t_side;

    logic        r_map;
    logic [30:0] r_ww, r_wd;
    logic [8:0]  r_cols, r_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= 1'b0; r_ww <= 31'd6553600; r_wd <= 31'd6553600;
            r_cols <= 9'd256; r_rows <= 9'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MAP_PRESENT:  r_map  <= i_cfg_data[0];
                REG_WORLD_WIDTH:  r_ww   <= i_cfg_data;
                REG_WORLD_DEPTH:  r_wd   <= i_cfg_data;
                REG_GRID_COLUMNS: r_cols <= i_cfg_data[8:0];
                REG_GRID_ROWS:    r_rows <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // saturated grid size
    logic [15:0] cols, rows;
    always_comb begin
        cols = (32'(r_cols) > MAX_COLUMNS) ? 16'(MAX_COLUMNS) : 16'(r_cols);
        rows = (32'(r_rows) > MAX_ROWS) ? 16'(MAX_ROWS) : 16'(r_rows);
    end
    logic cfg_ok;
    assign cfg_ok = r_map && r_ww != 0 && r_wd != 0 && cols >= 2 && rows >= 2;

    logic en;
    assign en = m_out.ready || !m_out.valid;
    assign s_in.ready = en;

    logic acc;
    assign acc = s_in.valid && en;

    // divider operands: magnitudes, floor via sign handling
    logic [31:0] ax, az;
    logic        nx, nz;
    always_comb begin
        nx = s_in.data.query_x[31];
        ax = nx ? 32'(-s_in.data.query_x) : s_in.data.query_x;
        nz = !s_in.data.query_z[31] && s_in.data.query_z != 0;
        az = s_in.data.query_z[31] ? 32'(-s_in.data.query_z) : s_in.data.query_z;
    end

    logic [16:0] qx, qz;
    logic        qxneg, qzneg, qxbig, qzbig, qxinex, qzinex;
    hbs_div u_divx (.i_clk, .i_en(en), .i_mag(ax), .i_neg(nx), .i_den(r_ww),
        .o_quo(qx), .o_neg(qxneg), .o_big(qxbig), .o_inexact(qxinex));
    hbs_div u_divz (.i_clk, .i_en(en), .i_mag(az), .i_neg(nz), .i_den(r_wd),
        .o_quo(qz), .o_neg(qzneg), .o_big(qzbig), .o_inexact(qzinex));

    // valid bits and write payload alongside the divider
    t_side                 n_side;
    logic [QDIV_STEPS-1:0] r_sv;
    t_side                 r_sd [QDIV_STEPS];
    always_comb begin
        n_side.query = (s_in.data.kind == KIND_QUERY);
        n_side.idx   = s_in.data.cell_index;
        n_side.hgt   = s_in.data.cell_height;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sv <= '0;
        else if (en) r_sv <= {r_sv[QDIV_STEPS-2:0], acc};
        if (en) begin
            r_sd[0] <= n_side;
            for (int k = 1; k < QDIV_STEPS; k++) r_sd[k] <= r_sd[k-1];
        end
    end

    // stage A: u, v and inside test
    logic [17:0] qxs, qzs;
    logic        xin, zin;
    logic [15:0] ux, vz;
    always_comb begin
        qxs = {1'b0, qx} + {17'd0, qxneg & qxinex};
        qzs = {1'b0, qz} + {17'd0, qzneg & qzinex};
        xin = !qxbig && (qxneg ? (qxs <= 18'd32768) : (qxs < 18'd32768));
        zin = !qzbig && (qzneg ? (qzs <= 18'd32768) : (qzs < 18'd32768));
        ux  = qxneg ? 16'(18'd32768 - qxs) : 16'(18'd32768 + qxs);
        vz  = qzneg ? 16'(18'd32768 - qzs) : 16'(18'd32768 + qzs);
    end
    logic        r_av, r_aq, r_ain;
    logic [15:0] r_u, r_v, r_aidx;
    logic [31:0] r_ahgt;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_av <= 1'b0;
        else if (en) r_av <= r_sv[QDIV_STEPS-1];
        if (en) begin
            r_aq   <= r_sd[QDIV_STEPS-1].query;
            r_aidx <= r_sd[QDIV_STEPS-1].idx;
            r_ahgt <= r_sd[QDIV_STEPS-1].hgt;
            r_ain  <= cfg_ok && xin && zin;
            r_u    <= ux;
            r_v    <= vz;
        end
    end

    // stage B: scale to grid
    logic [31:0] fx, fz;
    assign fx = 32'(r_u) * 32'(cols - 16'd1);
    assign fz = 32'(r_v) * 32'(rows - 16'd1);
    logic        r_bv, r_bq, r_bin;
    logic [15:0] r_ix, r_iz, r_dx, r_dz, r_bidx;
    logic [31:0] r_bhgt;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_bv <= 1'b0;
        else if (en) r_bv <= r_av;
        if (en) begin
            r_bq <= r_aq; r_bidx <= r_aidx; r_bhgt <= r_ahgt;
            r_bin <= r_ain;
            if (fx[31:16] > cols - 16'd2) begin
                r_ix <= cols - 16'd2; r_dx <= 16'(fx - 32'({cols - 16'd2, 16'd0}));
            end else begin
                r_ix <= fx[31:16]; r_dx <= fx[15:0];
            end
            if (fz[31:16] > rows - 16'd2) begin
                r_iz <= rows - 16'd2; r_dz <= 16'(fz - 32'({rows - 16'd2, 16'd0}));
            end else begin
                r_iz <= fz[31:16]; r_dz <= fz[15:0];
            end
        end
    end

    // stage C: address
    logic        r_cv, r_cq, r_cin;
    logic [15:0] r_a0, r_cdx, r_cdz, r_cidx;
    logic [31:0] r_chgt;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cv <= 1'b0;
        else if (en) r_cv <= r_bv;
        if (en) begin
            r_cq <= r_bq; r_cidx <= r_bidx; r_chgt <= r_bhgt;
            r_cin <= r_bin;
            r_a0  <= 16'(32'(r_iz) * 32'(cols) + 32'(r_ix));
            r_cdx <= r_dx; r_cdz <= r_dz;
        end
    end

    // stage D: grid writes land here; two copies, each read at two addresses
    logic [31:0] mem_lo [65536];
    logic [31:0] mem_hi [65536];
    logic        r_mv, r_min;
    logic [15:0] r_mdx, r_mdz;
    logic signed [31:0] r_h00, r_h10, r_h01, r_h11;
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_cv && !r_cq) mem_lo[r_cidx] <= r_chgt;
            r_h00 <= mem_lo[r_a0];
            r_h10 <= mem_lo[16'(r_a0 + 16'd1)];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_cv && !r_cq) mem_hi[r_cidx] <= r_chgt;
            r_h01 <= mem_hi[16'(r_a0 + cols)];
            r_h11 <= mem_hi[16'(r_a0 + cols + 16'd1)];
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mv <= 1'b0;
        else if (en) r_mv <= r_cv && r_cq;
        if (en) begin
            r_min <= r_cin; r_mdx <= r_cdx; r_mdz <= r_cdz;
        end
    end

    // stage E: lerp along x
    logic signed [49:0] e0, e1;
    assign e0 = r_h00 * $signed({1'b0, 17'(32'd65536 - 32'(r_mdx))})
              + r_h10 * $signed({1'b0, r_mdx});
    assign e1 = r_h01 * $signed({1'b0, 17'(32'd65536 - 32'(r_mdx))})
              + r_h11 * $signed({1'b0, r_mdx});
    logic        r_ev, r_ein;
    logic [15:0] r_edz;
    logic signed [33:0] r_h0, r_h1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ev <= 1'b0;
        else if (en) r_ev <= r_mv;
        if (en) begin
            r_ein <= r_min; r_edz <= r_mdz;
            r_h0 <= e0[49:16]; r_h1 <= e1[49:16];
        end
    end

    // stage F: lerp along z and output register
    logic signed [51:0] f;
    assign f = r_h0 * $signed({1'b0, 17'(32'd65536 - 32'(r_edz))})
             + r_h1 * $signed({1'b0, r_edz});
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) m_out.valid <= 1'b0;
        else if (en) m_out.valid <= r_ev;
        if (en) begin
            m_out.data.inside_res <= r_ein;
            m_out.data.height     <= r_ein ? f[47:16] : 32'sd0;
        end
    end
endmodule

FILE: bench/hbs_height_checker.sv
`timescale 1ns / 100ps
// Checker for heightmap_bilinear_sampler: tracks register writes and grid writes,
// predicts every query answer and compares it with the output channel. Uses hbs_pkg, hbs_if.
module hbs_height_checker
    import hbs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    hbs_if              in_ch,
    hbs_if              out_ch,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [30:0] i_cfg_data,
    output int          o_failures,
    output int          o_pending,
    output int          o_answers,
    output int          o_inside
);
    localparam int GRID_MAX_COLUMNS = 256;
    localparam int GRID_MAX_ROWS    = 256;
    localparam longint ONE_Q16      = 65536;

    logic [31:0] grid_heights [65536];
    logic        map_loaded;
    logic [30:0] extent_x;
    logic [30:0] extent_z;
    logic [8:0]  columns_reg;
    logic [8:0]  rows_reg;
    t_out_word   expected_heights[$];

    function automatic longint floor_quot(longint num, longint den);
        if (num >= 0) return num / den;
        return -((-num + den - 1) / den);
    endfunction

    function automatic longint blend(longint a, longint b, longint f);
        return floor_quot(a * (ONE_Q16 - f) + b * f, ONE_Q16);
    endfunction

    function automatic longint grid_at(logic [15:0] addr);
        return longint'($signed(grid_heights[addr]));
    endfunction

    function automatic t_out_word sample_height(t_in_word w);
        t_out_word   r;
        longint      cols, rows, u, v, fx, fz, ix, iz, dx, dz, h0, h1;
        logic [15:0] r0, r1;
        r.height = '0;
        r.inside_res = 1'b0;
        cols = columns_reg > GRID_MAX_COLUMNS ? GRID_MAX_COLUMNS : columns_reg;
        rows = rows_reg > GRID_MAX_ROWS ? GRID_MAX_ROWS : rows_reg;
        if (!map_loaded || extent_x == 0 || extent_z == 0 || cols < 2 || rows < 2) return r;
        u = 32768 + floor_quot(longint'(w.query_x) * ONE_Q16, longint'(extent_x));
        v = 32768 + floor_quot(-longint'(w.query_z) * ONE_Q16, longint'(extent_z));
        if (u < 0 || u >= ONE_Q16 || v < 0 || v >= ONE_Q16) return r;
        fx = u * (cols - 1);
        fz = v * (rows - 1);
        ix = fx / ONE_Q16;
        iz = fz / ONE_Q16;
        if (ix > cols - 2) ix = cols - 2;
        if (iz > rows - 2) iz = rows - 2;
        dx = fx - ix * ONE_Q16;
        dz = fz - iz * ONE_Q16;
        r0 = 16'(iz * cols + ix);
        r1 = 16'(r0 + cols);
        h0 = blend(grid_at(r0), grid_at(16'(r0 + 1)), dx);
        h1 = blend(grid_at(r1), grid_at(16'(r1 + 1)), dx);
        r.height = 32'(blend(h0, h1, dz));
        r.inside_res = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH answer %0d %s: got %0d expected %0d", o_answers, what, got, want);
        o_failures++;
    endtask

    assign o_pending = expected_heights.size();

    always @(posedge i_clk) begin
        t_out_word got, want;
        if (!i_rst_n) begin
            map_loaded <= 1'b0;
            extent_x <= 31'd6553600;
            extent_z <= 31'd6553600;
            columns_reg <= 9'd256;
            rows_reg <= 9'd256;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MAP_PRESENT:  map_loaded <= i_cfg_data[0];
                    REG_WORLD_WIDTH:  extent_x <= i_cfg_data;
                    REG_WORLD_DEPTH:  extent_z <= i_cfg_data;
                    REG_GRID_COLUMNS: columns_reg <= i_cfg_data[8:0];
                    REG_GRID_ROWS:    rows_reg <= i_cfg_data[8:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                if (in_ch.data.kind == KIND_WRITE)
                    grid_heights[in_ch.data.cell_index] = in_ch.data.cell_height;
                else
                    expected_heights.push_back(sample_height(in_ch.data));
            end
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (expected_heights.size() == 0) begin
                    report_mismatch("unexpected word", got.height, 0);
                end else begin
                    want = expected_heights.pop_front();
                    if (got.height !== want.height)
                        report_mismatch("height", got.height, want.height);
                    if (got.inside_res !== want.inside_res)
                        report_mismatch("inside", got.inside_res, want.inside_res);
                end
                o_answers++;
                if (got.inside_res === 1'b1) o_inside++;
            end
        end
    end
endmodule

FILE: bench/heightmap_bilinear_sampler_test.sv
`timescale 1ns / 100ps
// Top of the heightmap_bilinear_sampler bench: clock, reset, register phases, word stimulus,
// output stalls and verdict. Uses hbs_pkg, hbs_if, the block and hbs_height_checker.
module heightmap_bilinear_sampler_test;
    import hbs_pkg::*;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int LONG_HOLD     = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [30:0] i_cfg_data;
    int          failures, pending, answers, inside_count;
    int          cycles;
    int          idle_pct, stall_pct;
    int          hold_requests, holds_served;
    int          words_sent;
    longint      cur_width, cur_depth;
    int          cur_cols, cur_rows;

    hbs_if #(.T(t_in_word))  in_ch ();
    hbs_if #(.T(t_out_word)) out_ch ();

    heightmap_bilinear_sampler uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(in_ch.sink), .m_out(out_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    hbs_height_checker u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_failures(failures), .o_pending(pending), .o_answers(answers),
        .o_inside(inside_count)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d answers pending", cycles, pending);
            $display("heightmap_bilinear_sampler verification failed");
            $finish;
        end
    end

    initial begin
        int held;
        out_ch.ready = 1'b0;
        holds_served = 0;
        forever begin
            @(negedge i_clk);
            if (hold_requests > holds_served) begin
                holds_served++;
                out_ch.ready = 1'b0;
                for (held = 1; held < LONG_HOLD; held++) @(negedge i_clk);
            end else begin
                out_ch.ready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // start and end at a falling edge
    task automatic send_word(t_in_word w);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data = w;
        do @(posedge i_clk); while (!in_ch.ready);
        words_sent++;
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic write_cell(int index, logic [31:0] h);
        t_in_word w;
        w = '0;
        w.kind = KIND_WRITE;
        w.cell_index = 16'(index);
        w.cell_height = h;
        send_word(w);
    endtask

    task automatic query_at(logic [31:0] x, logic [31:0] z);
        t_in_word w;
        w = '0;
        w.kind = KIND_QUERY;
        w.query_x = x;
        w.query_z = z;
        w.cell_index = 16'($urandom);
        w.cell_height = $urandom;
        send_word(w);
    endtask

    task automatic write_reg(logic [2:0] index, logic [30:0] value);
        i_cfg_we = 1'b1;
        i_cfg_index = index;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic drain;
        int n;
        while (pending != 0) @(posedge i_clk);
        for (n = 0; n < SETTLE_CYCLES; n++) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_grid(logic present, longint w, longint d, int cols, int rows);
        drain();
        write_reg(REG_MAP_PRESENT, 31'(present));
        write_reg(REG_WORLD_WIDTH, 31'(w));
        write_reg(REG_WORLD_DEPTH, 31'(d));
        write_reg(REG_GRID_COLUMNS, 31'(cols));
        write_reg(REG_GRID_ROWS, 31'(rows));
        cur_width = w;
        cur_depth = d;
        cur_cols = cols > 256 ? 256 : cols;
        cur_rows = rows > 256 ? 256 : rows;
    endtask

    function automatic logic [31:0] any_height();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(200000)) - 32'd100000;
            default: return $urandom;
        endcase
    endfunction

    task automatic fill_grid;
        int n;
        for (n = 0; n < cur_cols * cur_rows; n++) write_cell(n, any_height());
    endtask

    task automatic random_traffic(int count);
        int     n;
        longint u, v;
        for (n = 0; n < count; n++) begin
            u = $urandom_range(65535);
            v = $urandom_range(65535);
            case ($urandom_range(9))
                0: write_cell($urandom_range(cur_cols * cur_rows - 1), any_height());
                1: query_at($urandom, $urandom);
                2: query_at(32'((u - 32768) * cur_width / 65536 + cur_width),
                            32'((32768 - v) * cur_depth / 65536));
                default: query_at(32'((u - 32768) * cur_width / 65536),
                                  32'((32768 - v) * cur_depth / 65536));
            endcase
        end
    endtask

    initial begin
        words_sent = 0;
        hold_requests = 0;
        idle_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_MAP_PRESENT;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        cur_width = 6553600;
        cur_depth = 6553600;
        cur_cols = 256;
        cur_rows = 256;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // map absent after reset: writes anywhere, queries answer outside
        write_cell(16'hFFFF, 32'h1234_5678);
        write_cell(0, 32'h8000_0000);
        query_at(0, 0);
        query_at(32'h8000_0000, 32'h7FFF_FFFF);
        drain();
        write_reg(REG_UNUSED, 31'h7FFF_FFFF);

        // smallest grid, extent 65536, extreme heights and edge positions
        set_grid(1'b1, 65536, 65536, 2, 2);
        write_cell(0, 32'h7FFF_FFFF);
        write_cell(1, 32'h8000_0000);
        write_cell(2, 32'h8000_0000);
        write_cell(3, 32'h7FFF_FFFF);
        query_at(32'hFFFF_8000, 32'h0000_8000);
        query_at(32'h0000_7FFF, 32'hFFFF_8001);
        query_at(32'h0000_8000, 0);
        query_at(0, 32'hFFFF_8000);
        query_at(0, 0);
        query_at(32'hFFFF_7FFF, 0);
        query_at(32'h8000_0000, 32'h8000_0000);
        query_at(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        query_at(32'h0000_4000, 32'hFFFF_C001);
        random_traffic(40);

        idle_pct = 65;
        set_grid(1'b1, 6553600, 6553600, 8, 6);
        fill_grid();
        random_traffic(100);

        idle_pct = 0;
        stall_pct = 65;
        set_grid(1'b1, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 511, 2);
        fill_grid();
        hold_requests++;
        random_traffic(60);

        idle_pct = 36;
        stall_pct = 36;
        set_grid(1'b1, 100000, 3000000, 2, 30);
        fill_grid();
        random_traffic(100);

        idle_pct = 0;
        stall_pct = 0;
        hold_requests++;
        set_grid(1'b1, 0, 6553600, 8, 8);
        random_traffic(15);
        set_grid(1'b1, 6553600, 0, 8, 8);
        random_traffic(15);
        set_grid(1'b1, 6553600, 6553600, 1, 0);
        random_traffic(15);
        set_grid(1'b0, 6553600, 6553600, 2, 256);
        random_traffic(15);
        set_grid(1'b1, 300000, 300000, 10, 8);
        fill_grid();
        random_traffic(60);

        drain();
        $display("sent %0d words over %0d cycles: grid fills, edge and random positions,",
                 words_sent, cycles);
        $display("%0d answers checked, %0d inside the map, through idle and stall phases",
                 answers, inside_count);
        if (failures == 0 && pending == 0) begin
            $display("heightmap_bilinear_sampler verification clean");
        end else begin
            $display("heightmap_bilinear_sampler verification failed");
        end
        $finish;
    end
endmodule

FILE: sim.f
design/hbs_pkg.sv
design/hbs_if.sv
design/hbs_div.sv
design/heightmap_bilinear_sampler.sv
bench/hbs_height_checker.sv
bench/heightmap_bilinear_sampler_test.sv
